// ===== src/scdec_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the sprite column command decoder.
// No dependencies; used by every module of the block but the checker.

package scdec_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CfgFlipScreen = 3'd0;
    localparam logic [2:0] CfgFlipXMask  = 3'd1;
    localparam logic [2:0] CfgFlipYMask  = 3'd2;
    localparam logic [2:0] CfgCodeMask   = 3'd3;
    localparam logic [2:0] CfgColourMask = 3'd4;

    // Configuration reset values.
    localparam logic        FlipScreenReset = 1'b0;
    localparam logic [15:0] FlipXMaskReset  = 16'h4000;
    localparam logic [15:0] FlipYMaskReset  = 16'h8000;
    localparam logic [15:0] CodeMaskReset   = 16'h3fff;
    localparam logic [7:0]  ColourMaskReset = 8'h7f;

    // Decode constants.
    localparam logic [15:0] CodeLimit = 16'h4fff;
    localparam logic [9:0]  FlipBase  = 10'd240;
    localparam logic [8:0]  TileStep  = 9'd16;

    // Default depth of the queue between decode and execute.
    localparam int QueueDepthDefault = 4;

    // Operation kinds carried through the queue.
    typedef enum logic [0:0] {
        OP_HEADER = 1'b0,
        OP_TILE   = 1'b1
    } op_kind_t;

    // One decoded operation, as handed from the front to the back.
    typedef struct packed {
        op_kind_t    kind;
        logic [9:0]  pos_x;
        logic [9:0]  pos_y;
        logic [14:0] tile_code;
        logic [7:0]  palette_colour;
        logic        mirror_x;
        logic        mirror_y;
        logic        draw;
        logic        step_down;
    } draw_op_t;

endpackage

// ===== src/scdec_front.sv =====
`timescale 1ns / 1ps
// Front end: holds the configuration registers, accepts word pairs and
// classifies them into header and tile operations. Depends on scdec_pkg.

module scdec_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                req_type,
    input  logic [15:0]         first_word,
    input  logic [15:0]         second_word,
    input  logic                cfg_valid,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic                queue_full,
    output logic                push,
    output scdec_pkg::draw_op_t push_op
);

    logic        flip_screen_reg;
    logic [15:0] flip_x_mask_reg;
    logic [15:0] flip_y_mask_reg;
    logic [15:0] code_mask_reg;
    logic [7:0]  colour_mask_reg;

    logic [8:0]  x_raw;
    logic [9:0]  x_pos;
    logic [9:0]  y_pos;
    logic [15:0] code_full;
    logic [7:0]  colour;
    logic        code_skip;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flip_screen_reg <= scdec_pkg::FlipScreenReset;
            flip_x_mask_reg <= scdec_pkg::FlipXMaskReset;
            flip_y_mask_reg <= scdec_pkg::FlipYMaskReset;
            code_mask_reg   <= scdec_pkg::CodeMaskReset;
            colour_mask_reg <= scdec_pkg::ColourMaskReset;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                scdec_pkg::CfgFlipScreen: flip_screen_reg <= cfg_data[0];
                scdec_pkg::CfgFlipXMask:  flip_x_mask_reg <= cfg_data;
                scdec_pkg::CfgFlipYMask:  flip_y_mask_reg <= cfg_data;
                scdec_pkg::CfgCodeMask:   code_mask_reg   <= cfg_data;
                scdec_pkg::CfgColourMask: colour_mask_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Header position: x from the x word and the y word's top bit, y negated.
    always_comb
    begin
        x_raw = {first_word[7:0], second_word[15]};
        x_pos = {x_raw[8], x_raw};
        y_pos = 10'd0 - {second_word[8], second_word[8:0]};
        if (flip_screen_reg)
        begin
            x_pos = scdec_pkg::FlipBase - x_pos;
            y_pos = scdec_pkg::FlipBase - y_pos;
        end
    end

    // Tile fields; an oversized code is dropped here and never queued.
    assign code_full = second_word & code_mask_reg;
    assign colour    = first_word[7:0] & colour_mask_reg;
    assign code_skip = req_type && (code_full > scdec_pkg::CodeLimit);

    always_comb
    begin
        push_op.kind           = req_type ? scdec_pkg::OP_TILE : scdec_pkg::OP_HEADER;
        push_op.pos_x          = x_pos;
        push_op.pos_y          = y_pos;
        push_op.tile_code      = code_full[14:0];
        push_op.palette_colour = colour;
        push_op.mirror_x       = (|(second_word & flip_x_mask_reg)) ^ flip_screen_reg;
        push_op.mirror_y       = (|(second_word & flip_y_mask_reg)) ^ flip_screen_reg;
        push_op.draw           = (colour != 8'd0);
        push_op.step_down      = flip_screen_reg;
    end

    assign in_ready = !queue_full;
    assign push     = in_valid && in_ready && !code_skip;

endmodule

// ===== src/scdec_fifo.sv =====
`timescale 1ns / 1ps
// Small first-in first-out queue of decoded operations between the
// front and back ends. Depends on scdec_pkg.

module scdec_fifo #(
    parameter int Depth = scdec_pkg::QueueDepthDefault
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  scdec_pkg::draw_op_t push_op,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output scdec_pkg::draw_op_t head_op
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

    scdec_pkg::draw_op_t entry_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign full       = (count_reg == FullCnt);
    assign head_valid = (count_reg != '0);
    assign head_op    = entry_reg[rd_ptr_reg];

endmodule

// ===== src/scdec_back.sv =====
`timescale 1ns / 1ps
// Back end: holds the column position, carries out queued operations and
// drives the registered draw command output. Depends on scdec_pkg.

module scdec_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  scdec_pkg::draw_op_t head_op,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [14:0]         tile_code,
    output logic [7:0]          palette_colour,
    output logic                mirror_x,
    output logic                mirror_y,
    output logic [9:0]          pos_x,
    output logic [9:0]          pos_y
);

    logic [9:0]  column_x_reg, column_x_next;
    logic [9:0]  column_y_reg, column_y_next;
    logic        out_valid_reg, out_valid_next;
    logic [14:0] tile_code_reg;
    logic [7:0]  palette_colour_reg;
    logic        mirror_x_reg;
    logic        mirror_y_reg;
    logic [9:0]  pos_x_reg;
    logic [9:0]  pos_y_reg;
    logic        is_draw;
    logic        out_free;
    logic        load_out;
    logic [8:0]  y_stepped;

    // A draw needs a free output slot; everything else retires at once.
    assign is_draw  = (head_op.kind == scdec_pkg::OP_TILE) && head_op.draw;
    assign out_free = !out_valid_reg || out_ready;
    assign pop      = head_valid && (!is_draw || out_free);
    assign load_out = pop && is_draw;

    // Column position update: headers load it, tiles step y by one tile.
    always_comb
    begin
        y_stepped     = head_op.step_down ? column_y_reg[8:0] - scdec_pkg::TileStep
                                          : column_y_reg[8:0] + scdec_pkg::TileStep;
        column_x_next = column_x_reg;
        column_y_next = column_y_reg;
        if (pop)
        begin
            case (head_op.kind)
                scdec_pkg::OP_HEADER:
                begin
                    column_x_next = head_op.pos_x;
                    column_y_next = head_op.pos_y;
                end
                scdec_pkg::OP_TILE:
                begin
                    column_y_next = {1'b0, y_stepped};
                end
                default: ;
            endcase
        end
    end

    // Output handshake state.
    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_x_reg  <= '0;
            column_y_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            column_x_reg  <= column_x_next;
            column_y_reg  <= column_y_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload, taken at the current column position.
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            tile_code_reg      <= head_op.tile_code;
            palette_colour_reg <= head_op.palette_colour;
            mirror_x_reg       <= head_op.mirror_x;
            mirror_y_reg       <= head_op.mirror_y;
            pos_x_reg          <= column_x_reg;
            pos_y_reg          <= column_y_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign tile_code      = tile_code_reg;
    assign palette_colour = palette_colour_reg;
    assign mirror_x       = mirror_x_reg;
    assign mirror_y       = mirror_y_reg;
    assign pos_x          = pos_x_reg;
    assign pos_y          = pos_y_reg;

endmodule

// ===== src/sprite_column_command_decoder.sv =====
`timescale 1ns / 1ps
// Top level of the sprite column command decoder: front end, queue and
// back end. Depends on scdec_pkg, scdec_front, scdec_fifo and scdec_back.
//
//  Channel  Direction  Handshake            Transaction
//  -------  ---------  -------------------  -------------------------------------
//  in       in         in_valid/in_ready    req_type, first_word, second_word
//  out      out        out_valid/out_ready  tile_code, palette_colour, mirror_*, pos_*
//  cfg      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One input transaction is taken per clock while the queue has room. A draw command
// passes through the queue entry and then the output register before it is shown.
// Reset clears the column position, the queue and the output valid, and
// loads the configuration defaults; no clearing pass is needed.
// When out_ready is held low, the output register and then the queue
// (QueueDepth entries) fill before in_ready drops. cfg_ready is always high.

module sprite_column_command_decoder #(
    parameter int QueueDepth = scdec_pkg::QueueDepthDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        req_type,
    input  logic [15:0] first_word,
    input  logic [15:0] second_word,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [14:0] tile_code,
    output logic [7:0]  palette_colour,
    output logic        mirror_x,
    output logic        mirror_y,
    output logic [9:0]  pos_x,
    output logic [9:0]  pos_y,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic                push;
    logic                pop;
    logic                queue_full;
    logic                head_valid;
    scdec_pkg::draw_op_t push_op;
    scdec_pkg::draw_op_t head_op;

    // Register writes are never stalled.
    assign cfg_ready = 1'b1;

    // Decode and classify incoming transactions.
    scdec_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .first_word  (first_word),
        .second_word (second_word),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .queue_full  (queue_full),
        .push        (push),
        .push_op     (push_op)
    );

    // Operation queue between the two halves.
    scdec_fifo #(
        .Depth (QueueDepth)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_op    (push_op),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_op    (head_op)
    );

    // Execute operations and drive draw commands.
    scdec_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_valid     (head_valid),
        .head_op        (head_op),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .tile_code      (tile_code),
        .palette_colour (palette_colour),
        .mirror_x       (mirror_x),
        .mirror_y       (mirror_y),
        .pos_x          (pos_x),
        .pos_y          (pos_y)
    );

endmodule

// ===== src/scdec_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the sprite column command decoder, bound to the
// top level. Depends on sprite_column_command_decoder's port list only.

module scdec_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [14:0] tile_code,
    input logic [7:0]  palette_colour,
    input logic        mirror_x,
    input logic        mirror_y,
    input logic [9:0]  pos_x,
    input logic [9:0]  pos_y
);

    // A stalled draw command holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(tile_code)
            && $stable(palette_colour) && $stable(pos_x) && $stable(pos_y)
            && $stable(mirror_x) && $stable(mirror_y))
        else $error("draw command changed while stalled");

    // Blank tiles never produce a draw command.
    a_colour_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> palette_colour != 8'd0)
        else $error("draw command with colour zero");

    // Oversized codes are dropped.
    a_code_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> tile_code <= 15'h4fff)
        else $error("draw command with oversized tile code");

    // No draw command is shown just as reset is released.
    a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !out_valid)
        else $error("draw command right after reset");

endmodule

bind sprite_column_command_decoder scdec_checker u_scdec_checker (.*);

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Testbench for sprite_column_command_decoder: directed and random column streams,
// with every draw command checked against a predicted one.
// Depends on scdec_pkg and the decoder RTL; needs no files or arguments.

module tb;
    import scdec_pkg::*;

    localparam int IdleLimit    = 1000;
    localparam int SettleCycles = 16;
    localparam int HoldCycles   = 80;
    localparam int PhaseItems   = 117;
    localparam int ReportLimit  = 40;

    // Index past the last register; writes to it must change nothing.
    localparam logic [2:0] CfgUnused = 3'd7;

    // One draw command as seen on the output channel.
    typedef struct {
        logic [14:0] tile_code;
        logic [7:0]  palette_colour;
        logic        mirror_x;
        logic        mirror_y;
        logic [9:0]  pos_x;
        logic [9:0]  pos_y;
    } draw_cmd_t;

    // Tracks the column position and registers, and queues the draw commands still due.
    class draw_command_predictor;
        logic        flip_screen;
        logic [15:0] flip_x_mask;
        logic [15:0] flip_y_mask;
        logic [15:0] code_mask;
        logic [7:0]  colour_mask;
        logic [9:0]  column_x;
        logic [9:0]  column_y;
        draw_cmd_t   expected_draws[$];
        int          mismatch_count;

        function new();
            flip_screen    = FlipScreenReset;
            flip_x_mask    = FlipXMaskReset;
            flip_y_mask    = FlipYMaskReset;
            code_mask      = CodeMaskReset;
            colour_mask    = ColourMaskReset;
            column_x       = '0;
            column_y       = '0;
            mismatch_count = 0;
        endfunction

        function void write_reg(logic [2:0] reg_index, logic [15:0] data);
            case (reg_index)
                CfgFlipScreen: flip_screen = data[0];
                CfgFlipXMask:  flip_x_mask = data;
                CfgFlipYMask:  flip_y_mask = data;
                CfgCodeMask:   code_mask   = data;
                CfgColourMask: colour_mask = data[7:0];
                default: ;
            endcase
        endfunction

        // Notes one accepted input transaction.
        function void take_pair(op_kind_t kind, logic [15:0] w1, logic [15:0] w2);
            logic [8:0]  x_raw;
            logic [9:0]  x_pos;
            logic [9:0]  y_pos;
            logic [15:0] code;
            logic [7:0]  colour;
            draw_cmd_t   cmd;
            if (kind == OP_HEADER) begin
                // The x word is shifted up and takes its low bit from y bit 15.
                x_raw = {w1[7:0], w2[15]};
                x_pos = {x_raw[8], x_raw};
                y_pos = 10'd0 - {w2[8], w2[8:0]};
                if (flip_screen) begin
                    x_pos = FlipBase - x_pos;
                    y_pos = FlipBase - y_pos;
                end
                column_x = x_pos;
                column_y = y_pos;
                return;
            end
            code = w2 & code_mask;
            // An oversized code is dropped and the column does not move.
            if (code > CodeLimit)
                return;
            colour = w1[7:0] & colour_mask;
            if (colour != 8'd0) begin
                cmd.tile_code      = code[14:0];
                cmd.palette_colour = colour;
                cmd.mirror_x       = (|(w2 & flip_x_mask)) ^ flip_screen;
                cmd.mirror_y       = (|(w2 & flip_y_mask)) ^ flip_screen;
                cmd.pos_x          = column_x;
                cmd.pos_y          = column_y;
                expected_draws.push_back(cmd);
            end
            // A blank colour still moves the column by one tile, wrapping at 9 bits.
            if (flip_screen)
                column_y = {1'b0, column_y[8:0] - TileStep};
            else
                column_y = {1'b0, column_y[8:0] + TileStep};
        endfunction

        function void report(string field, int want, int got);
            if (want != got) begin
                if (mismatch_count < ReportLimit)
                    $error("%s: expected %0d, actual %0d", field, want, got);
                mismatch_count++;
            end
        endfunction

        // Checks one accepted output transaction against the oldest prediction.
        function void match_draw(draw_cmd_t got);
            draw_cmd_t want;
            if (expected_draws.size() == 0) begin
                if (mismatch_count < ReportLimit)
                    $error("draw command with none due: tile_code %0h", got.tile_code);
                mismatch_count++;
                return;
            end
            want = expected_draws.pop_front();
            report("tile_code", want.tile_code, got.tile_code);
            report("palette_colour", want.palette_colour, got.palette_colour);
            report("mirror_x", want.mirror_x, got.mirror_x);
            report("mirror_y", want.mirror_y, got.mirror_y);
            report("pos_x", $signed(want.pos_x), $signed(got.pos_x));
            report("pos_y", $signed(want.pos_y), $signed(got.pos_y));
        endfunction

        function bit drained();
            return expected_draws.size() == 0;
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        req_type;
    logic [15:0] first_word;
    logic [15:0] second_word;
    logic        out_valid;
    logic        out_ready;
    logic [14:0] tile_code;
    logic [7:0]  palette_colour;
    logic        mirror_x;
    logic        mirror_y;
    logic [9:0]  pos_x;
    logic [9:0]  pos_y;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    draw_command_predictor predictor;
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int hold_ticket     = 0;
    int quiet_cycles    = 0;

    always #4 clk = ~clk;

    sprite_column_command_decoder uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .first_word     (first_word),
        .second_word    (second_word),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .tile_code      (tile_code),
        .palette_colour (palette_colour),
        .mirror_x       (mirror_x),
        .mirror_y       (mirror_y),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // Offers one word pair, after random idle cycles, and waits for the transaction.
    task automatic send_pair(op_kind_t kind, logic [15:0] w1, logic [15:0] w2);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        req_type    <= kind;
        first_word  <= w1;
        second_word <= w2;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predictor.take_pair(kind, w1, w2);
    endtask

    // Waits for every due draw command, then lets headers and skipped tiles drain.
    task automatic settle();
        while (!predictor.drained())
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    // Writes one register; the caller lowers cfg_valid after the last write.
    task automatic cfg_write(logic [2:0] reg_index, logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= reg_index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        predictor.write_reg(reg_index, data);
    endtask

    // Stops input, waits for the block to go idle, loads all five registers and may poke the unused one.
    task automatic load_setting(logic [15:0] fs, logic [15:0] fx, logic [15:0] fy,
                                logic [15:0] cm, logic [15:0] colm, bit poke_unused);
        in_valid <= 1'b0;
        settle();
        cfg_write(CfgFlipScreen, fs);
        cfg_write(CfgFlipXMask, fx);
        cfg_write(CfgFlipYMask, fy);
        cfg_write(CfgCodeMask, cm);
        cfg_write(CfgColourMask, colm);
        if (poke_unused)
            cfg_write(CfgUnused, 16'hffff);
        cfg_valid <= 1'b0;
    endtask

    // Mostly headers followed by runs of tiles, with some stray pairs mixed in.
    task automatic random_column_stream(int count);
        int          sent;
        int          tiles;
        logic [15:0] w1;
        logic [15:0] w2;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(9) == 0) begin
                send_pair(op_kind_t'($urandom_range(1)), 16'($urandom), 16'($urandom));
                sent++;
            end else begin
                send_pair(OP_HEADER, 16'($urandom), 16'($urandom));
                sent++;
                tiles = $urandom_range(1, 12);
                repeat (tiles) begin
                    w1 = 16'($urandom);
                    w2 = 16'($urandom);
                    // Blank some colours, and keep most codes within the limit.
                    if ($urandom_range(99) < 15)
                        w1 = w1 & ~{8'h00, predictor.colour_mask};
                    if ($urandom_range(99) < 70)
                        w2 = w2 & ~(predictor.code_mask & 16'hb000);
                    send_pair(OP_TILE, w1, w2);
                    sent++;
                end
            end
        end
    endtask

    // Main sequence: reset, directed cases, then random phases.
    initial begin
        predictor = new();
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        req_type    <= OP_HEADER;
        first_word  <= 16'h0000;
        second_word <= 16'h0000;
        cfg_valid   <= 1'b0;
        cfg_index   <= CfgFlipScreen;
        cfg_data    <= 16'h0000;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset registers: position extremes, mirrors, blank colour and y wrap.
        send_pair(OP_HEADER, 16'h0000, 16'h0000);
        send_pair(OP_TILE,   16'h0001, 16'h0000);
        send_pair(OP_TILE,   16'hffff, 16'hffff);
        send_pair(OP_TILE,   16'h0080, 16'h4000);
        send_pair(OP_HEADER, 16'hffff, 16'hffff);
        send_pair(OP_TILE,   16'h7f7f, 16'h8123);
        send_pair(OP_HEADER, 16'h0080, 16'h0100);
        send_pair(OP_TILE,   16'h0055, 16'h2aaa);
        send_pair(OP_HEADER, 16'h007f, 16'h80ff);
        send_pair(OP_TILE,   16'h002a, 16'h1555);
        send_pair(OP_HEADER, 16'h0000, 16'h00f8);
        send_pair(OP_TILE,   16'h0010, 16'h0000);
        send_pair(OP_TILE,   16'h0020, 16'h0000);

        // Flipped screen with wide masks: code limit edges and blank colour.
        load_setting(16'h8001, 16'h0001, 16'hffff, 16'hffff, 16'h12ff, 1'b1);
        send_pair(OP_HEADER, 16'h0000, 16'h0000);
        send_pair(OP_TILE,   16'h00ff, 16'h4fff);
        send_pair(OP_TILE,   16'h0001, 16'h5000);
        send_pair(OP_TILE,   16'h0001, 16'hffff);
        send_pair(OP_TILE,   16'hff00, 16'h0000);
        send_pair(OP_TILE,   16'h0080, 16'h0000);
        send_pair(OP_HEADER, 16'hffff, 16'h7fff);
        send_pair(OP_TILE,   16'h00c3, 16'h0002);

        // All-zero code and colour masks: no draw command at all.
        load_setting(16'hfffe, 16'hffff, 16'h0000, 16'h0000, 16'hff00, 1'b0);
        send_pair(OP_HEADER, 16'h1234, 16'h5678);
        send_pair(OP_TILE,   16'hffff, 16'hffff);
        send_pair(OP_TILE,   16'h00ff, 16'h0001);

        // Random phases, each with its own setting and idling pattern.
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: load_setting(16'h0000, 16'h4000, 16'h8000, 16'h3fff, 16'h007f, 1'b0);
                1: load_setting(16'h0001, 16'h4000, 16'h8000, 16'h7fff, 16'h00ff, 1'b0);
                2: load_setting(16'h0000, 16'hffff, 16'h0000, 16'hffff, 16'h00ff, 1'b0);
                3: load_setting(16'h0001, 16'h0000, 16'hffff, 16'h0000, 16'h0001, 1'b1);
                default: load_setting(16'(phase & 1), 16'($urandom), 16'($urandom),
                                      16'($urandom), 16'($urandom_range(1, 255)), 1'b0);
            endcase
            case (phase % 4)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 69; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 69; end
                default: begin sender_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            // Back-pressure: the output side holds off while input keeps coming.
            if (phase % 4 == 0)
                hold_ticket++;
            random_column_stream(PhaseItems);
        end

        in_valid <= 1'b0;
        settle();
        if (predictor.mismatch_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    // Output side: random stalls, plus a long hold-off whenever one is requested.
    initial begin
        int seen_ticket;
        seen_ticket = 0;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (hold_ticket != seen_ticket) begin
                seen_ticket = hold_ticket;
                out_ready <= 1'b0;
                repeat (HoldCycles) @(posedge clk);
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Checks each output transaction.
    always @(posedge clk) begin
        draw_cmd_t shown;
        if (rst_n && out_valid && out_ready) begin
            shown.tile_code      = tile_code;
            shown.palette_colour = palette_colour;
            shown.mirror_x       = mirror_x;
            shown.mirror_y       = mirror_y;
            shown.pos_x          = pos_x;
            shown.pos_y          = pos_y;
            predictor.match_draw(shown);
        end
    end

    // Watchdog: ends the run when no transaction of any kind happens for too long.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= IdleLimit) begin
            $display("tb: FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule
